[hdl/sacl_pkg.sv]
// ---------------------------------------------------------------------------
// sacl_pkg: shared constants for the LRU cache tag model
// Command and outcome codes, field widths and configuration register indexes.
// ---------------------------------------------------------------------------
package sacl_pkg;

    localparam int TAG_W = 62;
    localparam int CNT_W = 32;
    localparam int ADDR_W = 64;
    localparam int CMD_W = 2;
    localparam int OUTC_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam int SB_CFG_W = 3;
    localparam int OFS_CFG_W = 6;
    localparam int WAYS_CFG_W = 4;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 104;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STORE = 2'd1;

    localparam logic [OUTC_W-1:0] OUTC_HIT   = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_MISS  = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_EVICT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        t_BK_WAIT   = 2'b01,
        t_BK_UPDATE = 2'b10
    } t_bk_state;

endpackage

[hdl/sacl_fifo.sv]
// ---------------------------------------------------------------------------
// sacl_fifo: two-entry queue between front and back
// Holds classified accesses so each side can stall on its own.
// ---------------------------------------------------------------------------
module sacl_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr, r_rd_ptr;
    logic [1:0]       r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (i_pop)  r_rd_ptr <= ~r_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end

    // store entry
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

[hdl/sacl_front.sv]
// ---------------------------------------------------------------------------
// sacl_front: access intake and address split
// Drops instruction fetches and other commands, splits loads and stores into set and tag.
// ---------------------------------------------------------------------------
module sacl_front #(
    parameter int MAX_SET_BITS = 6
) (
    input  logic                                i_s_valid,
    input  logic [sacl_pkg::CMD_W-1:0]          i_command,
    input  logic [sacl_pkg::ADDR_W-1:0]         i_address,
    input  logic [sacl_pkg::SB_CFG_W-1:0]       i_set_bits,
    input  logic [sacl_pkg::OFS_CFG_W-1:0]      i_offset_bits,
    input  logic                                i_q_full,
    output logic                                o_s_ready,
    output logic                                o_push,
    output logic [MAX_SET_BITS+sacl_pkg::TAG_W-1:0] o_entry
);

    localparam int SBW = $clog2(MAX_SET_BITS + 1);

    logic [SBW-1:0]              sb;
    logic [6:0]                  shift;
    logic [sacl_pkg::ADDR_W-1:0] ofs_addr, tag_addr;
    logic [MAX_SET_BITS-1:0]     set_mask, set_idx;
    logic [sacl_pkg::TAG_W-1:0]  tag;

    assign o_s_ready = !i_q_full;
    assign o_push = i_s_valid && !i_q_full &&
                    ((i_command == sacl_pkg::CMD_LOAD) || (i_command == sacl_pkg::CMD_STORE));

    // split address by the configured geometry
    always_comb begin
        if (int'(i_set_bits) > MAX_SET_BITS) sb = SBW'(MAX_SET_BITS);
        else                                 sb = SBW'(i_set_bits);
        for (int b = 0; b < MAX_SET_BITS; b++) set_mask[b] = (b < int'(sb));
        ofs_addr = i_address >> i_offset_bits;
        set_idx  = ofs_addr[MAX_SET_BITS-1:0] & set_mask;
        shift    = 7'(i_offset_bits) + 7'(sb);
        tag_addr = i_address >> shift[5:0];
        tag      = shift[6] ? '0 : tag_addr[sacl_pkg::TAG_W-1:0];
    end

    assign o_entry = {set_idx, tag};

endmodule

[hdl/sacl_back.sv]
// ---------------------------------------------------------------------------
// sacl_back: set lookup, LRU update and result register
// Reads one set row, updates tags and ages, writes it back, emits result.
// ---------------------------------------------------------------------------
module sacl_back #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS = 8,
    parameter int AGE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_q_empty,
    input  logic [MAX_SET_BITS+sacl_pkg::TAG_W-1:0] i_q_data,
    output logic                                    o_pop,
    input  logic [sacl_pkg::WAYS_CFG_W-1:0]         i_ways_in_use,
    output logic                                    o_m_valid,
    input  logic                                    i_m_ready,
    output logic [sacl_pkg::M_DATA_W-1:0]           o_m_data
);

    localparam int NSETS  = 1 << MAX_SET_BITS;
    localparam int WCW    = $clog2(WAYS + 1);
    localparam int WIW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAGS_W = WAYS * sacl_pkg::TAG_W;
    localparam int ROW_W  = TAGS_W + WAYS * AGE_WIDTH + WCW;
    localparam int CW     = sacl_pkg::CNT_W;

    logic [ROW_W-1:0]           r_mem [NSETS];
    logic [NSETS-1:0]           r_row_valid;
    logic [ROW_W-1:0]           r_rd_row;
    logic                       r_rd_ok;
    logic [MAX_SET_BITS-1:0]    r_set;
    logic [sacl_pkg::TAG_W-1:0] r_tag;
    sacl_pkg::t_bk_state        r_state, n_state;
    logic [CW-1:0]              r_hits, r_misses, r_evicts, n_hits, n_misses, n_evicts;
    logic                       r_m_valid;
    logic [sacl_pkg::M_DATA_W-1:0] r_m_data;

    logic [ROW_W-1:0]           row, n_row;
    logic [WCW-1:0]             wy, fill, f;
    logic [sacl_pkg::TAG_W-1:0] way_tag;
    logic [AGE_WIDTH-1:0]       way_age [WAYS];
    logic                       found, commit;
    logic [WIW-1:0]             victim;
    logic [sacl_pkg::OUTC_W-1:0] outcome;

    assign o_pop     = (r_state == sacl_pkg::t_BK_WAIT) && !i_q_empty;
    assign commit    = (r_state == sacl_pkg::t_BK_UPDATE) && (!r_m_valid || i_m_ready);
    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;

    // next state
    always_comb begin
        case (r_state)
            sacl_pkg::t_BK_WAIT:   n_state = o_pop ? sacl_pkg::t_BK_UPDATE
                                                   : sacl_pkg::t_BK_WAIT;
            sacl_pkg::t_BK_UPDATE: n_state = commit ? sacl_pkg::t_BK_WAIT
                                                    : sacl_pkg::t_BK_UPDATE;
            default:               n_state = sacl_pkg::t_BK_WAIT;
        endcase
    end

    // update the set row: age, match, fill or evict
    always_comb begin
        row = r_rd_ok ? r_rd_row : '0;
        if (i_ways_in_use == '0)             wy = WCW'(1);
        else if (int'(i_ways_in_use) > WAYS) wy = WCW'(WAYS);
        else                                 wy = WCW'(i_ways_in_use);
        fill  = row[ROW_W-1 -: WCW];
        f     = (fill > wy) ? wy : fill;
        n_row = row;
        found = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            way_tag    = row[w*sacl_pkg::TAG_W +: sacl_pkg::TAG_W];
            way_age[w] = row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH];
            if (w < int'(f)) begin
                if (way_tag == r_tag) begin
                    way_age[w] = '0;
                    found = 1'b1;
                end else if (way_age[w] != '1) begin
                    way_age[w] = way_age[w] + AGE_WIDTH'(1);
                end
            end
        end
        // choose oldest way, lowest index on ties
        victim = '0;
        for (int w = 1; w < WAYS; w++) begin
            if (w < int'(wy) && way_age[w] > way_age[victim]) victim = WIW'(w);
        end
        outcome = sacl_pkg::OUTC_HIT;
        if (!found) begin
            if (f < wy) begin
                outcome = sacl_pkg::OUTC_MISS;
                n_row[ROW_W-1 -: WCW] = f + WCW'(1);
                for (int w = 0; w < WAYS; w++) begin
                    if (w == int'(f)) begin
                        n_row[w*sacl_pkg::TAG_W +: sacl_pkg::TAG_W] = r_tag;
                        way_age[w] = '0;
                    end
                end
            end else begin
                outcome = sacl_pkg::OUTC_EVICT;
                for (int w = 0; w < WAYS; w++) begin
                    if (w == int'(victim)) begin
                        n_row[w*sacl_pkg::TAG_W +: sacl_pkg::TAG_W] = r_tag;
                        way_age[w] = '0;
                    end
                end
            end
        end
        for (int w = 0; w < WAYS; w++) n_row[TAGS_W + w*AGE_WIDTH +: AGE_WIDTH] = way_age[w];
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (outcome == sacl_pkg::OUTC_HIT) begin
            if (r_hits != '1) n_hits = r_hits + CW'(1);
        end else begin
            if (r_misses != '1) n_misses = r_misses + CW'(1);
            if (outcome == sacl_pkg::OUTC_EVICT && r_evicts != '1)
                n_evicts = r_evicts + CW'(1);
        end
    end

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sacl_pkg::t_BK_WAIT;
            r_row_valid <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_row_valid[r_set] <= 1'b1;
                r_hits    <= n_hits;
                r_misses  <= n_misses;
                r_evicts  <= n_evicts;
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // set memory read and write-back; hold access and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_row <= r_mem[i_q_data[sacl_pkg::TAG_W +: MAX_SET_BITS]];
            r_rd_ok  <= r_row_valid[i_q_data[sacl_pkg::TAG_W +: MAX_SET_BITS]];
            r_set    <= i_q_data[sacl_pkg::TAG_W +: MAX_SET_BITS];
            r_tag    <= i_q_data[sacl_pkg::TAG_W-1:0];
        end
        if (commit) begin
            r_mem[r_set] <= n_row;
            r_m_data     <= {6'd0, n_evicts, n_misses, n_hits, outcome};
        end
    end

endmodule

[hdl/set_assoc_cache_lru_sim.sv]
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_sim: tag-only set-associative cache with LRU
// Counts hits, misses and evictions of a load/store address stream.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one access per transfer: command and address.
//   Loads and stores each give one transfer on the master stream m_*;
//   instruction fetches and other commands are absorbed and give nothing.
//   Configuration is written through i_cfg_* while the block is idle.
// Timing:
//   An accepted access is classified into a two-entry queue in the same
//   cycle. The back end reads the set row (registered memory read) and
//   then writes it back while loading the result register. It takes a
//   new access from the queue only once the last one is written back,
//   set by the read-then-write of the set memory.
// Reset:
//   i_rst_n clears counters, queue and the per-set valid flags, so every
//   set reads as empty at once; no clearing pass. Config resets to 1.
// Stall:
//   When m_tready is low the result is held, the back end stops, the queue
//   fills and s_tready drops.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int WAYS = 8,
    parameter int AGE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [1:0] command, [65:2] address, [71:66] zero
    input  logic [sacl_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [1:0] outcome, [33:2] hit_total, [65:34] miss_total,
    // [97:66] eviction_total, [103:98] zero
    output logic [sacl_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                 i_cfg_wr_en,
    input  logic [sacl_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int ENT_W = MAX_SET_BITS + sacl_pkg::TAG_W;

    logic [sacl_pkg::SB_CFG_W-1:0]   r_set_bits;
    logic [sacl_pkg::OFS_CFG_W-1:0]  r_offset_bits;
    logic [sacl_pkg::WAYS_CFG_W-1:0] r_ways_in_use;

    logic             push, pop, q_full, q_empty;
    logic [ENT_W-1:0] entry, q_data;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits    <= sacl_pkg::SB_CFG_W'(1);
            r_offset_bits <= sacl_pkg::OFS_CFG_W'(1);
            r_ways_in_use <= sacl_pkg::WAYS_CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sacl_pkg::CFG_SET_BITS:
                    r_set_bits <= i_cfg_wdata[sacl_pkg::SB_CFG_W-1:0];
                sacl_pkg::CFG_OFFSET_BITS:
                    r_offset_bits <= i_cfg_wdata;
                sacl_pkg::CFG_WAYS_IN_USE:
                    r_ways_in_use <= i_cfg_wdata[sacl_pkg::WAYS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    sacl_front #(
        .MAX_SET_BITS(MAX_SET_BITS)
    ) u_front (
        .i_s_valid    (s_tvalid),
        .i_command    (s_tdata[1:0]),
        .i_address    (s_tdata[65:2]),
        .i_set_bits   (r_set_bits),
        .i_offset_bits(r_offset_bits),
        .i_q_full     (q_full),
        .o_s_ready    (s_tready),
        .o_push       (push),
        .o_entry      (entry)
    );

    sacl_fifo #(
        .WIDTH(ENT_W)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (entry),
        .i_pop  (pop),
        .o_data (q_data),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    sacl_back #(
        .MAX_SET_BITS(MAX_SET_BITS),
        .WAYS        (WAYS),
        .AGE_WIDTH   (AGE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_pop        (pop),
        .i_ways_in_use(r_ways_in_use),
        .o_m_valid    (m_tvalid),
        .i_m_ready    (m_tready),
        .o_m_data     (m_tdata)
    );

endmodule

[dv/tb_set_assoc_cache_lru_sim.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_set_assoc_cache_lru_sim: self-checking bench for the LRU cache tag model
// Drives load, store and fetch accesses under several geometries, predicts
// outcome and running counts per access, and compares every result transfer.
// ---------------------------------------------------------------------------
module tb_set_assoc_cache_lru_sim;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int AGE_MAX = 65535;
    localparam logic [sacl_pkg::CMD_W-1:0] CMD_FETCH = 2'd2;
    localparam logic [sacl_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic [sacl_pkg::OUTC_W-1:0] outcome;
        logic [sacl_pkg::CNT_W-1:0]  hits;
        logic [sacl_pkg::CNT_W-1:0]  misses;
        logic [sacl_pkg::CNT_W-1:0]  evicts;
    } t_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [sacl_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [sacl_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            i_cfg_wr_en;
    logic [sacl_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [sacl_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    // shadow cache state
    logic [sacl_pkg::TAG_W-1:0] sh_tag [NSETS][NWAYS];
    int unsigned                sh_age [NSETS][NWAYS];
    int unsigned                sh_fill [NSETS];
    logic [sacl_pkg::CNT_W-1:0] sh_hits, sh_misses, sh_evicts;
    int unsigned                cfg_sets, cfg_offset, cfg_ways;

    t_result     expected_results [$];
    int          mismatch_count;
    int          unexpected_count;
    bit          hold_off;
    bit          offering;

    set_assoc_cache_lru_sim u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [sacl_pkg::CNT_W-1:0] sat_inc(logic [sacl_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Apply one access to the shadow cache and queue its expected result.
    function automatic void predict_access(logic [sacl_pkg::CMD_W-1:0] cmd,
                                           logic [sacl_pkg::ADDR_W-1:0] addr);
        int unsigned sb, ways, fill, set_idx, shift, victim;
        logic [sacl_pkg::TAG_W-1:0] tag;
        bit found;
        t_result r;
        if (cmd != sacl_pkg::CMD_LOAD && cmd != sacl_pkg::CMD_STORE) return;
        sb = (cfg_sets > 6) ? 6 : cfg_sets;
        ways = (cfg_ways == 0) ? 1 : ((cfg_ways > NWAYS) ? NWAYS : cfg_ways);
        set_idx = 32'((addr >> cfg_offset) & ((64'd1 << sb) - 1));
        shift = cfg_offset + sb;
        tag = (shift >= 64) ? '0 : sacl_pkg::TAG_W'(addr >> shift);
        fill = (sh_fill[set_idx] > ways) ? ways : sh_fill[set_idx];
        found = 0;
        for (int i = 0; i < fill; i++) begin
            if (sh_tag[set_idx][i] == tag) begin
                sh_age[set_idx][i] = 0;
                found = 1;
            end else if (sh_age[set_idx][i] < AGE_MAX) begin
                sh_age[set_idx][i]++;
            end
        end
        if (found) begin
            sh_hits = sat_inc(sh_hits);
            r.outcome = sacl_pkg::OUTC_HIT;
        end else if (fill < ways) begin
            sh_tag[set_idx][fill] = tag;
            sh_age[set_idx][fill] = 0;
            sh_fill[set_idx] = fill + 1;
            sh_misses = sat_inc(sh_misses);
            r.outcome = sacl_pkg::OUTC_MISS;
        end else begin
            victim = 0;
            for (int i = 1; i < ways; i++)
                if (sh_age[set_idx][i] > sh_age[set_idx][victim]) victim = i;
            sh_tag[set_idx][victim] = tag;
            sh_age[set_idx][victim] = 0;
            sh_misses = sat_inc(sh_misses);
            sh_evicts = sat_inc(sh_evicts);
            r.outcome = sacl_pkg::OUTC_EVICT;
        end
        r.hits = sh_hits;
        r.misses = sh_misses;
        r.evicts = sh_evicts;
        expected_results.push_back(r);
    endfunction

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            t_result got, exp_r;
            got.outcome = m_tdata[1:0];
            got.hits = m_tdata[33:2];
            got.misses = m_tdata[65:34];
            got.evicts = m_tdata[97:66];
            if (expected_results.size() == 0) begin
                unexpected_count++;
                if (mismatch_count + unexpected_count <= 10)
                    $display("unexpected result %h", m_tdata);
            end else begin
                exp_r = expected_results.pop_front();
                if (got != exp_r) begin
                    mismatch_count++;
                    if (mismatch_count + unexpected_count <= 10)
                        $display({"mismatch: exp outc=%0d h=%0d m=%0d e=%0d, ",
                                  "got outc=%0d h=%0d m=%0d e=%0d"},
                            exp_r.outcome, exp_r.hits, exp_r.misses, exp_r.evicts,
                            got.outcome, got.hits, got.misses, got.evicts);
                end
            end
        end
    end

    // Receiver: draw a random wait per result, plus a long hold-off.
    initial begin
        int wait_left;
        wait_left = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (m_tready && m_tvalid) begin
                wait_left = $urandom_range(0, 10);
                m_tready <= (wait_left == 0);
            end else if (wait_left > 1) begin
                wait_left--;
                m_tready <= 1'b0;
            end else begin
                wait_left = 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Drop the input valid unless it is already dropped.
    task automatic stop_input;
        if (offering) begin
            s_tvalid <= 1'b0;
            offering = 0;
        end
    endtask

    // Send one access, after a random gap unless no_gap is set, and wait for its transfer.
    task automatic send_access(logic [sacl_pkg::CMD_W-1:0] cmd,
                               logic [sacl_pkg::ADDR_W-1:0] addr,
                               bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10));
        if (gap > 0) begin
            stop_input();
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, addr, cmd};
        offering = 1;
        do @(posedge i_clk); while (!s_tready);
        predict_access(cmd, addr);
    endtask

    // Wait for all results, then let the fetch tail drain before a write.
    task automatic drain;
        stop_input();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             logic [sacl_pkg::CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            sacl_pkg::CFG_SET_BITS:    cfg_sets = val & 7;
            sacl_pkg::CFG_OFFSET_BITS: cfg_offset = val;
            sacl_pkg::CFG_WAYS_IN_USE: cfg_ways = val & 15;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int sb, int ofs, int ways);
        drain();
        write_cfg(sacl_pkg::CFG_SET_BITS, sacl_pkg::CFG_DATA_W'(sb));
        write_cfg(sacl_pkg::CFG_OFFSET_BITS, sacl_pkg::CFG_DATA_W'(ofs));
        write_cfg(sacl_pkg::CFG_WAYS_IN_USE, sacl_pkg::CFG_DATA_W'(ways));
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [sacl_pkg::ADDR_W-1:0] rand_addr();
        return {$urandom(), $urandom()};
    endfunction

    // Address built from a small tag, set and offset under the current mapping.
    function automatic logic [sacl_pkg::ADDR_W-1:0] mapped_addr(int tag_v, int set_v);
        int sb;
        sb = (cfg_sets > 6) ? 6 : cfg_sets;
        return (((64'(tag_v) << sb) | 64'(set_v)) << cfg_offset)
               | (64'($urandom()) & ((64'd1 << cfg_offset) - 1));
    endfunction

    // Extremes, every command and reset geometry.
    task automatic test_directed;
        send_access(sacl_pkg::CMD_LOAD, '0);
        send_access(sacl_pkg::CMD_STORE, '0);
        send_access(sacl_pkg::CMD_LOAD, '1);
        send_access(sacl_pkg::CMD_STORE, '1);
        send_access(CMD_FETCH, 64'h1234);
        send_access(CMD_SPARE, '1);
        send_access(sacl_pkg::CMD_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_access(sacl_pkg::CMD_STORE, 64'h5555_5555_5555_5555);
        send_access(sacl_pkg::CMD_LOAD, 64'h8000_0000_0000_0000);
    endtask

    // Fill a set, evict the oldest ways, hit, then evict again and reload an evicted tag.
    task automatic test_lru_order;
        set_geometry(2, 4, 4);
        for (int t = 0; t < 6; t++) send_access(sacl_pkg::CMD_LOAD, mapped_addr(t, 1));
        send_access(sacl_pkg::CMD_STORE, mapped_addr(3, 1));
        send_access(sacl_pkg::CMD_LOAD, mapped_addr(9, 1));
        send_access(sacl_pkg::CMD_LOAD, mapped_addr(2, 1));
    endtask

    // Wide shift: offset plus set bits reach 64, so every tag is zero; then ways clamped.
    task automatic test_wide_shift;
        set_geometry(7, 63, 8);
        for (int i = 0; i < 6; i++) send_access(sacl_pkg::CMD_LOAD, rand_addr());
        set_geometry(0, 1, 0);
        for (int i = 0; i < 4; i++) send_access(sacl_pkg::CMD_STORE, rand_addr());
        set_geometry(1, 1, 15);
        for (int i = 0; i < 4; i++) send_access(sacl_pkg::CMD_LOAD, {2'b11, 62'(i)});
    endtask

    // Shrink ways below the fill and remap without flushing.
    task automatic test_reconfig;
        set_geometry(3, 5, 8);
        for (int t = 0; t < 10; t++) send_access(sacl_pkg::CMD_LOAD, mapped_addr(t, 2));
        set_geometry(3, 5, 2);
        for (int t = 0; t < 6; t++) send_access(sacl_pkg::CMD_LOAD, mapped_addr(t, 2));
        set_geometry(6, 32, 8);
    endtask

    // Stall the receiver for a long stretch while accesses keep coming.
    task automatic test_backpressure;
        drain();
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 12; i++)
                    send_access(sacl_pkg::CMD_W'($urandom_range(0, 1)), rand_addr(), 1);
                stop_input();
            end
            begin
                repeat (60) @(posedge i_clk);
                hold_off = 0;
            end
        join
    endtask

    // Random accesses: mostly reuse of a small working set per phase.
    task automatic test_random;
        int sb_v, ofs_v, ways_v;
        logic [sacl_pkg::CMD_W-1:0] cmd;
        logic [sacl_pkg::ADDR_W-1:0] addr;
        for (int phase = 0; phase < 8; phase++) begin
            sb_v = $urandom_range(0, 7);
            ofs_v = (phase == 0) ? 32 : (phase == 1) ? 1 : $urandom_range(0, 63);
            ways_v = (phase == 2) ? 8 : $urandom_range(0, 15);
            set_geometry(sb_v, ofs_v, ways_v);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(0, 9) == 0)
                    cmd = CMD_FETCH + sacl_pkg::CMD_W'($urandom_range(0, 1));
                else
                    cmd = sacl_pkg::CMD_W'($urandom_range(0, 1));
                if ($urandom_range(0, 9) < 8)
                    addr = mapped_addr($urandom_range(0, 11), $urandom_range(0, 3));
                else
                    addr = rand_addr();
                send_access(cmd, addr, $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        hold_off = 0;
        offering = 0;
        mismatch_count = 0;
        unexpected_count = 0;
        sh_hits = '0;
        sh_misses = '0;
        sh_evicts = '0;
        cfg_sets = 1;
        cfg_offset = 1;
        cfg_ways = 1;
        for (int s = 0; s < NSETS; s++) begin
            sh_fill[s] = 0;
            for (int w = 0; w < NWAYS; w++) begin
                sh_tag[s][w] = '0;
                sh_age[s][w] = 0;
            end
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_lru_order();
        test_wide_shift();
        test_reconfig();
        test_backpressure();
        test_random();
        drain();
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && unexpected_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
